// File: rtl/core/regression_score_metrics_top_defines.svh
// Assertion macros shared by the regression score metrics RTL.
`ifndef REGRESSION_SCORE_METRICS_TOP_DEFINES_SVH
`define REGRESSION_SCORE_METRICS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rsm_pkg.sv
// Package with types and fixed constants of the regression score metrics block.
`default_nettype none
package rsm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAX_COUNT = 65536;
	localparam int CNT_W     = $clog2(MAX_COUNT + 1);
	localparam int SQ_W      = 2 * SAMPLE_W;
	localparam int SUM_W     = 33;
	localparam int SQS_W     = 47;
	localparam int SSE_W     = 48;
	localparam int MSE_W     = 48;
	localparam int R2_W      = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 64;
	localparam int DVD_W     = PROD_W + FRAC_W;
	localparam int DCNT_W    = $clog2(DVD_W);

	// Ratio limit: a quotient of 32769.0 or more saturates r2.
	localparam logic [DVD_W-1:0] SAT_LIMIT = DVD_W'(32769) << FRAC_W;
	localparam logic [R2_W-1:0]  ONE_Q16   = R2_W'(1) << FRAC_W;
	localparam logic [R2_W-1:0]  R2_SAT    = R2_W'(1) << (R2_W - 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] actual;
		logic signed [SAMPLE_W-1:0] predicted;
		logic                       last;
	} in_t;

	typedef struct packed {
		logic [MSE_W-1:0]       mse;
		logic signed [R2_W-1:0] r2;
		logic                   status;
	} out_t;

	// Final sums of one vector, handed from the accumulator to the solver.
	typedef struct packed {
		logic [CNT_W-1:0]        n;
		logic signed [SUM_W-1:0] sy;
		logic [SQS_W-1:0]        s2;
		logic [SSE_W-1:0]        sse;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage
`default_nettype wire

// File: rtl/core/rsm_front.sv
// Front end: takes sample pairs, squares them and accumulates the vector sums.
`default_nettype none
module rsm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire rsm_pkg::in_t   sample,
	input  wire rsm_pkg::qstat_t qstat,
	output logic                push,
	output rsm_pkg::job_t       push_job
);
	import rsm_pkg::*;

	logic                    valid_s1;
	logic                    last_s1;
	logic signed [SAMPLE_W-1:0] act_s1;
	logic [SQ_W-1:0]         asq_s1;
	logic [SQ_W-1:0]         dsq_s1;

	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sa_q;
	logic [SQS_W-1:0]        ssq_q;
	logic [SSE_W-1:0]        sse_q;

	logic signed [SAMPLE_W:0]     diff;
	logic signed [2*SAMPLE_W+1:0] dprod;
	logic signed [2*SAMPLE_W-1:0] aprod;
	logic                         take;
	job_t                         nxt;

	// A marked pair in stage one waits while the queue has no room.
	assign busy = valid_s1 && last_s1 && qstat.full;
	assign take = start && !busy;

	assign diff  = (SAMPLE_W+1)'(sample.actual) - (SAMPLE_W+1)'(sample.predicted);
	assign dprod = diff * diff;
	assign aprod = sample.actual * sample.actual;

	always_comb begin
		nxt.n   = cnt_q;
		nxt.sy  = sa_q;
		nxt.s2  = ssq_q;
		nxt.sse = sse_q;
		if (cnt_q < CNT_W'(MAX_COUNT)) begin
			nxt.n   = cnt_q + 1'b1;
			nxt.sy  = sa_q + SUM_W'(act_s1);
			nxt.s2  = ssq_q + SQS_W'(asq_s1);
			nxt.sse = sse_q + SSE_W'(dsq_s1);
		end
	end

	assign push     = valid_s1 && last_s1 && !busy;
	assign push_job = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (!busy) begin
			valid_s1 <= take;
			last_s1  <= sample.last;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_s1 <= sample.actual;
			asq_s1 <= SQ_W'(aprod);
			dsq_s1 <= SQ_W'(dprod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sa_q  <= '0;
			ssq_q <= '0;
			sse_q <= '0;
		end else if (valid_s1 && !busy) begin
			if (last_s1) begin
				cnt_q <= '0;
				sa_q  <= '0;
				ssq_q <= '0;
				sse_q <= '0;
			end else begin
				cnt_q <= nxt.n;
				sa_q  <= nxt.sy;
				ssq_q <= nxt.s2;
				sse_q <= nxt.sse;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/rsm_queue.sv
// Small FIFO of finished vector sums between the accumulator and the solver.
`default_nettype none
module rsm_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rsm_pkg::job_t   push_job,
	input  wire logic            pop,
	output rsm_pkg::job_t        head,
	output rsm_pkg::qstat_t      qstat
);
	import rsm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/rsm_back.sv
// Back end: shift-add products and a shared restoring divider for MSE and R2.
`default_nettype none
module rsm_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rsm_pkg::job_t   head,
	input  wire rsm_pkg::qstat_t qstat,
	output logic                 pop,
	output logic                 valid,
	output rsm_pkg::out_t        result
);
	import rsm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIVM = 2'd2;
	localparam logic [1:0] ST_DIVR = 2'd3;

	logic [1:0]         state_q;

	logic [PROD_W-1:0]  mc_sse_q;
	logic [PROD_W-1:0]  mc_s2_q;
	logic [PROD_W-1:0]  mc_sy_q;
	logic [CNT_W-1:0]   mp_n_q;
	logic [SUM_W-1:0]   mp_sy_q;
	logic [PROD_W-1:0]  acc_num_q;
	logic [PROD_W-1:0]  acc_ns2_q;
	logic [PROD_W-1:0]  acc_sy2_q;
	logic [PROD_W-1:0]  den_q;

	logic [DVD_W-1:0]   dvd_q;
	logic [PROD_W-1:0]  dvs_q;
	logic [PROD_W-1:0]  rem_q;
	logic [DVD_W-1:0]   quo_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [MSE_W-1:0]   mse_q;

	// The multiplicands are shifted away during the product loop, so the SSE and
	// the count of the popped vector are kept here for the MSE division.
	logic [SSE_W-1:0]   sse_keep_q;
	logic [CNT_W-1:0]   n_keep_q;

	logic [SUM_W-1:0]   sy_mag;
	logic [PROD_W:0]    trial;
	logic               ge;
	logic [PROD_W-1:0]  rem_nx;
	logic [DVD_W-1:0]   quo_nx;
	logic               dlast;
	logic               done;

	assign sy_mag = head.sy[SUM_W-1] ? SUM_W'(-head.sy) : SUM_W'(head.sy);

	// One quotient bit per cycle, most significant first.
	assign trial  = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = (trial >= {1'b0, dvs_q});
	assign rem_nx = ge ? PROD_W'(trial - {1'b0, dvs_q}) : PROD_W'(trial);
	assign quo_nx = {quo_q[DVD_W-2:0], ge};
	assign dlast  = (dcnt_q == DCNT_W'(DVD_W - 1));

	assign pop = (state_q == ST_IDLE) && !qstat.empty;

	// A result is ready in the cycle that finishes its last step.
	assign done = ((state_q == ST_IDLE) && !qstat.empty && (head.n == '0))
		|| ((state_q == ST_DIVM) && dlast && (den_q == '0))
		|| ((state_q == ST_DIVR) && dlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid   <= 1'b0;
		end else begin
			valid <= done;
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty && head.n != '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mp_n_q == '0 && mp_sy_q == '0) begin
						state_q <= ST_DIVM;
					end
				end
				ST_DIVM: begin
					if (dlast) begin
						if (den_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIVR;
						end
					end
				end
				ST_DIVR: begin
					if (dlast) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mc_sse_q  <= PROD_W'(head.sse);
				mc_s2_q   <= PROD_W'(head.s2);
				mc_sy_q   <= PROD_W'(sy_mag);
				mp_n_q    <= head.n;
				mp_sy_q   <= sy_mag;
				acc_num_q <= '0;
				acc_ns2_q <= '0;
				acc_sy2_q <= '0;
				if (!qstat.empty && head.n == '0) begin
					result.mse    <= '0;
					result.r2     <= '0;
					result.status <= 1'b1;
				end
			end
			ST_MUL: begin
				if (mp_n_q[0]) begin
					acc_num_q <= acc_num_q + mc_sse_q;
					acc_ns2_q <= acc_ns2_q + mc_s2_q;
				end
				if (mp_sy_q[0]) begin
					acc_sy2_q <= acc_sy2_q + mc_sy_q;
				end
				mc_sse_q <= mc_sse_q << 1;
				mc_s2_q  <= mc_s2_q << 1;
				mc_sy_q  <= mc_sy_q << 1;
				mp_n_q   <= mp_n_q >> 1;
				mp_sy_q  <= mp_sy_q >> 1;
				if (mp_n_q == '0 && mp_sy_q == '0) begin
					den_q  <= acc_ns2_q - acc_sy2_q;
					dvd_q  <= DVD_W'(sse_keep_q) << FRAC_W;
					dvs_q  <= PROD_W'(n_keep_q);
					rem_q  <= '0;
					quo_q  <= '0;
					dcnt_q <= '0;
				end
			end
			ST_DIVM: begin
				if (dlast && den_q != '0) begin
					// The R2 division reuses the divider right away.
					dvd_q  <= {acc_num_q, FRAC_W'(0)};
					dvs_q  <= den_q;
					rem_q  <= '0;
					quo_q  <= '0;
					dcnt_q <= '0;
				end else begin
					dvd_q  <= dvd_q << 1;
					rem_q  <= rem_nx;
					quo_q  <= quo_nx;
					dcnt_q <= dcnt_q + 1'b1;
				end
				if (dlast) begin
					mse_q <= quo_nx[MSE_W-1:0];
					if (den_q == '0) begin
						result.mse    <= quo_nx[MSE_W-1:0];
						result.r2     <= '0;
						result.status <= 1'b1;
					end
				end
			end
			ST_DIVR: begin
				dvd_q  <= dvd_q << 1;
				rem_q  <= rem_nx;
				quo_q  <= quo_nx;
				dcnt_q <= dcnt_q + 1'b1;
				if (dlast) begin
					result.mse    <= mse_q;
					result.status <= 1'b0;
					if (quo_nx >= SAT_LIMIT) begin
						result.r2 <= R2_SAT;
					end else begin
						result.r2 <= ONE_Q16 - quo_nx[R2_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sse_keep_q <= head.sse;
			n_keep_q   <= head.n;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/regression_score_metrics_top.sv
// Top level of the regression score metrics block (MSE and R2 score).
//
//  Channel   Direction  Handshake                Payload
//  request   in         start / busy             sample  (actual, predicted, last)
//  result    out        valid, one-cycle strobe  result  (mse, r2, status)
//
// A request is taken at a rising edge with start high and busy low; while busy is
// low, one pair a cycle is accumulated. The pair marked last closes the vector: it
// passes stage one and the sums are pushed into a queue of QUEUE_DEPTH entries,
// and the next vector can stream in. The solver pops a vector, runs a shift-add
// product loop, then two restoring divisions (a vector with zero variance skips
// the second). It sets the rate when vectors are short.
// busy rises only while a marked pair waits for room in the full queue.
// The receiver cannot stall; valid is high for exactly one cycle per result.
// Reset clears the accumulators, the queue and the solver sequencer.
`default_nettype none
module regression_score_metrics_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rsm_pkg::in_t  sample,
	output logic               valid,
	output rsm_pkg::out_t      result
);
	import rsm_pkg::*;

	// Handoff between the front end, the queue and the solver.
	logic   push;
	logic   pop;
	job_t   push_job;
	job_t   head;
	qstat_t qstat;

	// The front end squares each pair in its first stage and adds the squares
	// into the running sums in its second stage.
	rsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.sample   (sample),
		.qstat    (qstat),
		.push     (push),
		.push_job (push_job)
	);

	// The queue lets a new vector accumulate while the solver still works.
	rsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// The solver forms n*SSE and n*sum(y^2) - sum(y)^2 bit by bit, then divides.
	rsm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.valid  (valid),
		.result (result)
	);

`include "regression_score_metrics_top_defines.svh"

	// The front end only stalls when the queue is out of room.
	`RSM_ASSERT_NOW(a_busy_full, clk, arst_n, busy, qstat.full, "busy without full queue")

	// A zero-variance result always carries a zero R2 score.
	`RSM_ASSERT_NOW(a_status_r2, clk, arst_n, valid && result.status, result.r2 == '0, "r2 set")

	// R2 never exceeds 1.0.
	`RSM_ASSERT_NOW(a_r2_max, clk, arst_n, valid, result.r2 <= $signed(ONE_Q16), "r2 above one")

	// The solver needs many cycles per vector, so results never come back to back.
	`RSM_ASSERT_NEXT(a_gap, clk, arst_n, valid, !valid, "results in consecutive cycles")

	// Nothing is pushed into a full queue.
	`RSM_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !qstat.full, "push into full queue")

endmodule
`default_nettype wire

// File: bench/tb_regression_score_metrics_top.sv
// Self-checking bench for the regression score block: MSE and R2 scores of sample vectors.

// Keeps running sums of the accepted sample pairs, works out the score of each closed
// vector, and matches the block's scores against them in order.
class score_ledger;
	localparam longint unsigned RATIO_CEIL = 32769;

	longint unsigned pairs;
	longint unsigned sum_y;
	longint unsigned sum_y2;
	longint unsigned sum_err2;
	rsm_pkg::out_t   expected_scores[$];
	int              mismatches;
	int              scores_checked;
	int              flat_vectors;
	int              floored_scores;

	function new();
		clear_sums();
		mismatches     = 0;
		scores_checked = 0;
		flat_vectors   = 0;
		floored_scores = 0;
	endfunction

	function void clear_sums();
		pairs    = 0;
		sum_y    = 0;
		sum_y2   = 0;
		sum_err2 = 0;
	endfunction

	function rsm_pkg::out_t solve_score();
		longint unsigned n, q, rem, num, den, sy_mag, frac;
		rsm_pkg::out_t   r;
		int              i;
		r = '0;
		n = pairs;
		if (n == 0) begin
			r.status = 1'b1;
			return r;
		end
		q      = sum_err2 / n;
		rem    = sum_err2 % n;
		r.mse  = 48'((q << rsm_pkg::FRAC_W) + ((rem << rsm_pkg::FRAC_W) / n));
		sy_mag = sum_y[63] ? -sum_y : sum_y;
		num    = n * sum_err2;
		den    = n * sum_y2 - sy_mag * sy_mag;
		if (den == 0) begin
			r.status = 1'b1;
			flat_vectors++;
		end else begin
			q   = num / den;
			rem = num % den;
			if (q >= RATIO_CEIL) begin
				r.r2 = rsm_pkg::R2_SAT;
				floored_scores++;
			end else begin
				// Restoring division of the remainder, one fraction bit per step.
				frac = 0;
				for (i = 0; i < rsm_pkg::FRAC_W; i++) begin
					frac <<= 1;
					if (rem >= den - rem) begin
						rem  = rem - (den - rem);
						frac |= 1;
					end else begin
						rem <<= 1;
					end
				end
				r.r2 = 32'(rsm_pkg::ONE_Q16 - ((q << rsm_pkg::FRAC_W) + frac));
			end
		end
		return r;
	endfunction

	function void take_pair(rsm_pkg::in_t s);
		longint y, d;
		y = longint'(s.actual);
		d = y - longint'(s.predicted);
		// Once the count is full, further pairs are dropped but a marker still closes.
		if (pairs < rsm_pkg::MAX_COUNT) begin
			pairs++;
			sum_y    += y;
			sum_y2   += y * y;
			sum_err2 += d * d;
		end
		if (s.last) begin
			expected_scores.push_back(solve_score());
			clear_sums();
		end
	endfunction

	function void match_score(rsm_pkg::out_t got);
		rsm_pkg::out_t want;
		if (expected_scores.size() == 0) begin
			$error("unexpected score: mse %h r2 %h status %b", got.mse, got.r2, got.status);
			mismatches++;
			return;
		end
		want = expected_scores.pop_front();
		scores_checked++;
		if (got.mse !== want.mse) begin
			$error("mse: expected %h, actual %h", want.mse, got.mse);
			mismatches++;
		end
		if (got.r2 !== want.r2) begin
			$error("r2: expected %h, actual %h", want.r2, got.r2);
			mismatches++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %b, actual %b", want.status, got.status);
			mismatches++;
		end
	endfunction
endclass

module tb_regression_score_metrics_top;

	// No accepted request and no score for this many cycles means the block hung.
	// At most three vectors wait while the solver works.
	localparam int QUIET_LIMIT = 4000;
	// Cycles to watch for stray scores once every expected one has arrived.
	localparam int TAIL_CYCLES = 600;
	localparam int PHASE_PAIRS = 470;

	// Shapes of random vectors, each aimed at a different corner of the scoring math.
	typedef enum {
		FIT_WILD,     // both values over the full range
		FIT_CLOSE,    // prediction within a few counts of the actual value
		FIT_FLAT,     // one actual value for the whole vector, so zero variance
		FIT_SWAMPED,  // tiny actual spread, wild predictions: drives R2 to its floor
		FIT_BIASED    // prediction off by a single flipped bit
	} fit_t;

	logic          clk    = 1'b0;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	rsm_pkg::in_t  sample = '0;
	logic          busy;
	logic          valid;
	rsm_pkg::out_t result;

	score_ledger ledger = new();
	int          idle_pct      = 0;
	int          requests_sent = 0;
	int          quiet_cycles  = 0;

	always #1 clk = ~clk;

	regression_score_metrics_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.valid  (valid),
		.result (result)
	);

	// Observe both channels at the rising edge. The bench and the block only change
	// signals through nonblocking updates, so what is read here is the value that the
	// edge acts on. A score is checked before the request of the same edge is noted,
	// since a score can never belong to a pair taken at that very edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid)
				ledger.match_score(result);
			if (start && !busy)
				ledger.take_pair(sample);
		end
	end

	// Watchdog: any accepted request or score restarts the count.
	always @(posedge clk) begin
		if (!arst_n || valid || (start && !busy)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("regression_score_metrics_top regression: fail");
				$finish;
			end
		end
	end

	function automatic rsm_pkg::in_t make_pair(int a, int p, logic last);
		rsm_pkg::in_t s;
		s.actual    = 16'(a);
		s.predicted = 16'(p);
		s.last      = last;
		return s;
	endfunction

	// Offer one request, with random idle cycles in front of it at the current idle
	// rate. While idle, the payload carries noise that the block must not take in.
	// Returns at the edge that accepted the request.
	task automatic send_pair(input rsm_pkg::in_t s);
		while ($urandom_range(99) < idle_pct) begin
			start  <= 1'b0;
			sample <= make_pair($urandom, $urandom, 1'($urandom));
			@(posedge clk);
		end
		start  <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// Stop sending and hold off until every outstanding score has come back.
	// The first edge lets the final request of the vector reach the ledger.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.expected_scores.size() != 0)
			@(posedge clk);
	endtask

	// One vector of the given length and shape; only its final pair carries the marker.
	task automatic send_vector(input int len, input fit_t shape);
		logic [15:0] a, p, base;
		int          i;
		base = 16'($urandom);
		for (i = 0; i < len; i++) begin
			case (shape)
				FIT_CLOSE: begin
					a = 16'($urandom);
					p = 16'(a + $urandom_range(15) - 8);
				end
				FIT_FLAT: begin
					a = base;
					p = 16'($urandom);
				end
				FIT_SWAMPED: begin
					a = 16'($urandom_range(1));
					p = 16'($urandom);
				end
				FIT_BIASED: begin
					a = 16'($urandom);
					p = a ^ (16'd1 << $urandom_range(15));
				end
				default: begin
					a = 16'($urandom);
					p = 16'($urandom);
				end
			endcase
			send_pair(make_pair(int'(a), int'(p), i == len - 1));
		end
	endtask

	// Random vectors until the phase has sent its share of requests. Most vectors are
	// short, since the solver and not the accumulator sets the pace for those; a few
	// run long so that large sums and products get exercised.
	task automatic run_phase(input int pairs_wanted);
		int goal, len, pick;
		goal = requests_sent + pairs_wanted;
		while (requests_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 70)
				len = $urandom_range(6, 1);
			else if (pick < 95)
				len = $urandom_range(32, 7);
			else
				len = $urandom_range(160, 33);
			pick = $urandom_range(9);
			if (pick < 4)
				send_vector(len, FIT_WILD);
			else if (pick < 6)
				send_vector(len, FIT_CLOSE);
			else if (pick < 7)
				send_vector(len, FIT_FLAT);
			else if (pick < 8)
				send_vector(len, FIT_SWAMPED);
			else
				send_vector(len, FIT_BIASED);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed vectors, sent back to back.
		// A single pair at the range extremes: zero variance, largest possible MSE.
		send_pair(make_pair(32767, -32768, 1'b1));
		// Every bit pattern at both extremes; a mixed-sign vector.
		send_pair(make_pair(-32768, -32768, 1'b0));
		send_pair(make_pair(32767, 32767, 1'b0));
		send_pair(make_pair(-32768, 32767, 1'b1));
		// A perfect fit: R2 is exactly one.
		send_pair(make_pair(-1200, -1200, 1'b0));
		send_pair(make_pair(5, 5, 1'b0));
		send_pair(make_pair(31000, 31000, 1'b1));
		// Several equal actual values: zero variance with a nonzero MSE.
		send_pair(make_pair(100, 50, 1'b0));
		send_pair(make_pair(100, -3, 1'b0));
		send_pair(make_pair(100, 7, 1'b1));
		// Ratio of exactly 32768.0, a score that is not clipped.
		send_pair(make_pair(0, -128, 1'b0));
		send_pair(make_pair(1, 1, 1'b1));
		// Ratio of 32767.5, just inside the range.
		send_pair(make_pair(0, -146, 1'b0));
		send_pair(make_pair(0, -23, 1'b0));
		send_pair(make_pair(1, 1, 1'b1));
		// Ratio of exactly 32769.0: the score clips to its floor.
		send_pair(make_pair(0, -146, 1'b0));
		send_pair(make_pair(0, -23, 1'b0));
		send_pair(make_pair(1, 0, 1'b1));
		// A far worse fit, clipped too.
		send_pair(make_pair(0, -32768, 1'b0));
		send_pair(make_pair(1, -32768, 1'b1));
		// Small values around zero.
		send_pair(make_pair(-1, 0, 1'b0));
		send_pair(make_pair(0, -1, 1'b0));
		send_pair(make_pair(1, 1, 1'b1));
		drain();

		// Random traffic: a light sender idle rate, then a heavy one, then none.
		idle_pct = 15;
		run_phase(PHASE_PAIRS);
		drain();
		idle_pct = 68;
		run_phase(PHASE_PAIRS);
		drain();
		idle_pct = 0;
		run_phase(PHASE_PAIRS);
		drain();

		// Give the block time to emit any score that it should not.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d sample pairs in directed and random vectors at three idle rates.",
			requests_sent);
		$display("Checked %0d scores: %0d with flat actual values, %0d clipped at the floor.",
			ledger.scores_checked, ledger.flat_vectors, ledger.floored_scores);
		if (ledger.mismatches == 0 && ledger.expected_scores.size() == 0)
			$display("regression_score_metrics_top regression: pass");
		else
			$display("regression_score_metrics_top regression: fail");
		$finish;
	end

endmodule
